@@ sv/tps_pkg.sv @@
// package: payload types, codes and pattern table for the tone pattern sequencer
package tps_pkg;

    localparam int NOW_W     = 32;
    localparam int FREQ_W    = 13;
    localparam int DUR_W     = 9;
    localparam int LEN_W     = 5;
    localparam int POS_W     = 4;
    localparam int PAT_W     = 3;
    localparam int SLOT_W    = 4;
    localparam int PRIO_W    = 2;
    localparam int REPS_W    = 8;
    localparam int GUARD_W   = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MUTE       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITIES = 8'd1;
    localparam logic [CFG_DAT_W-1:0] PRIO_RESET     = 16'd5800;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_PLAY    = 2'd1,
        OP_STOP    = 2'd2,
        OP_STOP_IF = 2'd3
    } tps_op_t;

    typedef struct packed {
        tps_op_t           op;
        logic [PAT_W-1:0]  pattern_id;
        logic              force_req;
        logic [NOW_W-1:0]  now_ms;
    } tps_in_t;

    typedef struct packed {
        logic              accepted;
        logic              playing;
        logic [FREQ_W-1:0] freq_hz;
        logic              changed;
    } tps_out_t;

    typedef struct packed {
        logic [FREQ_W-1:0] hz;
        logic [DUR_W-1:0]  dur;
        logic [LEN_W-1:0]  len;
        logic [REPS_W-1:0] reps;
        logic              endless;
    } tps_step_info_t;

    typedef enum logic [1:0] {
        SUB_ELAPSE = 2'd0,
        SUB_WALK   = 2'd1,
        SUB_SETTLE = 2'd2
    } tps_sub_sel_t;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_EXEC   = 3'd1,
        S_ELAPSE = 3'd2,
        S_WALK   = 3'd3,
        S_SETTLE = 3'd4,
        S_EMIT   = 3'd5
    } tps_state_t;

    function automatic logic [FREQ_W-1:0] rom_hz(input logic [SLOT_W-1:0] slot,
                                                 input logic [POS_W-1:0] pos);
        logic [FREQ_W-1:0] hz;
        hz = '0;
        case ({slot, pos})
            8'h00: hz = 13'd1800;
            8'h02: hz = 13'd2400;
            8'h10: hz = 13'd2700;
            8'h20: hz = 13'd2200;
            8'h22: hz = 13'd3100;
            8'h30: hz = 13'd2600;
            8'h32: hz = 13'd2100;
            8'h34: hz = 13'd1600;
            8'h40: hz = 13'd3100;
            8'h42: hz = 13'd3100;
            8'h50: hz = 13'd2500;
            8'h60: hz = 13'd3400;
            8'h62: hz = 13'd3900;
            8'h70: hz = 13'd1400;
            8'h72: hz = 13'd1100;
            default: hz = '0;
        endcase
        return hz;
    endfunction

    function automatic logic [DUR_W-1:0] rom_dur(input logic [SLOT_W-1:0] slot,
                                                 input logic [POS_W-1:0] pos);
        logic [DUR_W-1:0] dur;
        dur = '0;
        case ({slot, pos})
            8'h00: dur = 9'd70;
            8'h01: dur = 9'd40;
            8'h02: dur = 9'd70;
            8'h10: dur = 9'd250;
            8'h20: dur = 9'd200;
            8'h21: dur = 9'd90;
            8'h22: dur = 9'd350;
            8'h30: dur = 9'd90;
            8'h31: dur = 9'd60;
            8'h32: dur = 9'd90;
            8'h33: dur = 9'd60;
            8'h34: dur = 9'd140;
            8'h40: dur = 9'd120;
            8'h41: dur = 9'd70;
            8'h42: dur = 9'd120;
            8'h50: dur = 9'd300;
            8'h51: dur = 9'd200;
            8'h60: dur = 9'd120;
            8'h61: dur = 9'd80;
            8'h62: dur = 9'd120;
            8'h63: dur = 9'd380;
            8'h70: dur = 9'd200;
            8'h71: dur = 9'd120;
            8'h72: dur = 9'd300;
            default: dur = '0;
        endcase
        return dur;
    endfunction

    function automatic logic [LEN_W-1:0] rom_len(input logic [SLOT_W-1:0] slot);
        logic [LEN_W-1:0] len;
        len = '0;
        case (slot)
            4'd0: len = 5'd3;
            4'd1: len = 5'd1;
            4'd2: len = 5'd3;
            4'd3: len = 5'd5;
            4'd4: len = 5'd3;
            4'd5: len = 5'd2;
            4'd6: len = 5'd4;
            4'd7: len = 5'd3;
            default: len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [REPS_W-1:0] rom_reps(input logic [SLOT_W-1:0] slot);
        logic [REPS_W-1:0] reps;
        reps = '0;
        case (slot)
            4'd2: reps = 8'd1;
            default: reps = '0;
        endcase
        return reps;
    endfunction

    function automatic logic rom_endless(input logic [SLOT_W-1:0] slot);
        logic e;
        e = 1'b0;
        case (slot)
            4'd5: e = 1'b1;
            4'd6: e = 1'b1;
            default: e = 1'b0;
        endcase
        return e;
    endfunction

endpackage

@@ sv/tone_pattern_sequencer.sv @@
// top level: tone pattern sequencer with control sequencer, state and output register
// Plays buzzer tone patterns from a built-in table; one item is handled at a time and
// s_ready is high only while the sequencer is idle. Stop and stop-if end in the execute
// state and give no result; play, a tick on an idle block and the first tick after a
// play go from execute to emit; any other tick runs through elapse, walk, settle and
// emit, advancing at most len*4+4 steps, and a tick that ends the pattern goes from the
// walk straight to emit. The catch-up walk runs through one shared 32-bit subtractor,
// one step compare per cycle. A result goes into the output register, and the next
// item is taken while it waits; the sequencer holds only when a new result finds the
// register still full.
module tone_pattern_sequencer import tps_pkg::*; #(
    parameter int NUM_PATTERNS = 8,
    parameter int MAX_STEPS    = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tps_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tps_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    tps_state_t            state_reg, state_next;
    tps_in_t               item_reg, item_next;
    logic                  running_reg, running_next;
    logic                  primed_reg, primed_next;
    logic [PAT_W-1:0]      active_pattern_reg, active_pattern_next;
    logic [POS_W-1:0]      step_pos_reg, step_pos_next;
    logic [REPS_W-1:0]     loop_count_reg, loop_count_next;
    logic [NOW_W-1:0]      step_start_reg, step_start_next;
    logic [PRIO_W-1:0]     active_priority_reg, active_priority_next;
    logic [FREQ_W-1:0]     last_freq_reg, last_freq_next;
    logic [NOW_W-1:0]      rem_reg, rem_next;
    logic [GUARD_W-1:0]    guard_reg, guard_next;
    logic                  res_accepted_reg, res_accepted_next;
    logic                  mute_reg;
    logic [CFG_DAT_W-1:0]  prio_reg;
    logic                  m_valid_reg, m_valid_next;
    tps_out_t              m_data_reg, m_data_next;

    logic [PAT_W-1:0]      rom_pattern;
    tps_step_info_t        info;
    tps_sub_sel_t          sub_sel;
    logic [NOW_W-1:0]      sub_diff;
    logic                  sub_borrow;
    logic [PRIO_W-1:0]     req_prio;
    logic                  play_ok;
    logic                  walk_go;
    logic [LEN_W-1:0]      pos_inc;
    logic [FREQ_W-1:0]     tone;

    tps_step_rom #(
        .NUM_PATTERNS(NUM_PATTERNS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_rom (
        .pattern_id(rom_pattern),
        .step_pos  (step_pos_reg),
        .info      (info)
    );

    tps_sub_unit u_sub (
        .sel       (sub_sel),
        .now_ms    (item_reg.now_ms),
        .step_start(step_start_reg),
        .rem       (rem_reg),
        .dur       (info.dur),
        .diff      (sub_diff),
        .borrow    (sub_borrow)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign rom_pattern = (state_reg == S_EXEC && item_reg.op == OP_PLAY) ?
                         item_reg.pattern_id : active_pattern_reg;

    always_comb begin
        case (state_reg)
            S_IDLE:   sub_sel = SUB_ELAPSE;
            S_ELAPSE: sub_sel = SUB_ELAPSE;
            S_WALK:   sub_sel = SUB_WALK;
            S_SETTLE: sub_sel = SUB_SETTLE;
            default:  sub_sel = SUB_ELAPSE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            running_reg         <= 1'b0;
            primed_reg          <= 1'b0;
            active_pattern_reg  <= '0;
            step_pos_reg        <= '0;
            loop_count_reg      <= '0;
            step_start_reg      <= '0;
            active_priority_reg <= '0;
            last_freq_reg       <= '0;
            mute_reg            <= 1'b0;
            prio_reg            <= PRIO_RESET;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg           <= state_next;
            running_reg         <= running_next;
            primed_reg          <= primed_next;
            active_pattern_reg  <= active_pattern_next;
            step_pos_reg        <= step_pos_next;
            loop_count_reg      <= loop_count_next;
            step_start_reg      <= step_start_next;
            active_priority_reg <= active_priority_next;
            last_freq_reg       <= last_freq_next;
            m_valid_reg         <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MUTE) begin
                    mute_reg <= cfg_data[0];
                end else if (cfg_index == CFG_PRIORITIES) begin
                    prio_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        rem_reg          <= rem_next;
        guard_reg        <= guard_next;
        res_accepted_reg <= res_accepted_next;
        m_data_reg       <= m_data_next;
    end

    always_comb begin
        state_next           = state_reg;
        item_next            = item_reg;
        running_next         = running_reg;
        primed_next          = primed_reg;
        active_pattern_next  = active_pattern_reg;
        step_pos_next        = step_pos_reg;
        loop_count_next      = loop_count_reg;
        step_start_next      = step_start_reg;
        active_priority_next = active_priority_reg;
        last_freq_next       = last_freq_reg;
        rem_next             = rem_reg;
        guard_next           = guard_reg;
        res_accepted_next    = res_accepted_reg;
        m_data_next          = m_data_reg;
        m_valid_next         = m_valid_reg && !m_ready;

        req_prio    = prio_reg[{item_reg.pattern_id, 1'b0} +: PRIO_W];
        play_ok     = (info.len != '0) &&
                      !(running_reg && !item_reg.force_req && req_prio < active_priority_reg);
        walk_go     = (guard_reg != '0) && ({1'b0, step_pos_reg} < info.len) && !sub_borrow;
        pos_inc     = {1'b0, step_pos_reg} + LEN_W'(1);
        tone        = (running_reg && !mute_reg && ({1'b0, step_pos_reg} < info.len)) ?
                      info.hz : '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_accepted_next = 1'b0;
                case (item_reg.op)
                    OP_PLAY: begin
                        res_accepted_next = play_ok;
                        if (play_ok) begin
                            active_pattern_next  = item_reg.pattern_id;
                            active_priority_next = req_prio;
                            step_pos_next        = '0;
                            loop_count_next      = '0;
                            running_next         = 1'b1;
                            primed_next          = 1'b0;
                            step_start_next      = item_reg.now_ms;
                        end
                        state_next = S_EMIT;
                    end
                    OP_STOP: begin
                        running_next         = 1'b0;
                        step_pos_next        = '0;
                        active_priority_next = '0;
                        primed_next          = 1'b0;
                        state_next           = S_IDLE;
                    end
                    OP_STOP_IF: begin
                        if (running_reg && active_pattern_reg == item_reg.pattern_id) begin
                            running_next         = 1'b0;
                            step_pos_next        = '0;
                            active_priority_next = '0;
                            primed_next          = 1'b0;
                        end
                        state_next = S_IDLE;
                    end
                    OP_TICK: begin
                        if (!running_reg) begin
                            state_next = S_EMIT;
                        end else if (!primed_reg) begin
                            primed_next     = 1'b1;
                            step_start_next = item_reg.now_ms;
                            state_next      = S_EMIT;
                        end else begin
                            guard_next = {info.len, 2'b00} + GUARD_W'(4);
                            state_next = S_ELAPSE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ELAPSE: begin
                rem_next   = sub_diff;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (walk_go) begin
                    guard_next = guard_reg - GUARD_W'(1);
                    rem_next   = sub_diff;
                    if (pos_inc >= info.len) begin
                        step_pos_next = '0;
                        if (info.endless) begin
                            state_next = S_WALK;
                        end else if (loop_count_reg < info.reps) begin
                            loop_count_next = loop_count_reg + REPS_W'(1);
                        end else begin
                            // pattern finished: idle, anchor at this tick
                            running_next         = 1'b0;
                            active_priority_next = '0;
                            primed_next          = 1'b1;
                            step_start_next      = item_reg.now_ms;
                            state_next           = S_EMIT;
                        end
                    end else begin
                        step_pos_next = pos_inc[POS_W-1:0];
                    end
                end else begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE: begin
                step_start_next = sub_diff;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.playing  = running_reg;
                    m_data_next.freq_hz  = tone;
                    if (item_reg.op == OP_TICK) begin
                        m_data_next.accepted = 1'b0;
                        m_data_next.changed  = (tone != last_freq_reg);
                        last_freq_next       = tone;
                    end else begin
                        m_data_next.accepted = res_accepted_reg;
                        m_data_next.changed  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/tps_step_rom.sv @@
// pattern table lookup: step tone, duration and pattern length, repeats, endless flag
module tps_step_rom import tps_pkg::*; #(
    parameter int NUM_PATTERNS = 8,
    parameter int MAX_STEPS    = 8
) (
    input  logic [PAT_W-1:0] pattern_id,
    input  logic [POS_W-1:0] step_pos,
    output tps_step_info_t   info
);

    localparam logic [LEN_W-1:0] NUM_PAT_L   = LEN_W'(NUM_PATTERNS);
    localparam logic [LEN_W-1:0] MAX_STEPS_L = LEN_W'(MAX_STEPS);

    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  raw_len;

    always_comb begin
        slot    = {1'b0, pattern_id};
        raw_len = rom_len(slot);
        info.hz      = rom_hz(slot, step_pos);
        info.dur     = rom_dur(slot, step_pos);
        info.reps    = rom_reps(slot);
        info.endless = rom_endless(slot);
        if ({2'b00, pattern_id} >= NUM_PAT_L) begin
            info.len = '0;
        end else if (raw_len > MAX_STEPS_L) begin
            info.len = MAX_STEPS_L;
        end else begin
            info.len = raw_len;
        end
    end

endmodule

@@ sv/tps_sub_unit.sv @@
// shared 32-bit subtractor with operand select for elapsed time, step walk and re-anchor
module tps_sub_unit import tps_pkg::*; (
    input  tps_sub_sel_t      sel,
    input  logic [NOW_W-1:0]  now_ms,
    input  logic [NOW_W-1:0]  step_start,
    input  logic [NOW_W-1:0]  rem,
    input  logic [DUR_W-1:0]  dur,
    output logic [NOW_W-1:0]  diff,
    output logic              borrow
);

    logic [NOW_W-1:0] op_a;
    logic [NOW_W-1:0] op_b;

    always_comb begin
        case (sel)
            SUB_ELAPSE: begin
                op_a = now_ms;
                op_b = step_start;
            end
            SUB_WALK: begin
                op_a = rem;
                op_b = {{(NOW_W-DUR_W){1'b0}}, dur};
            end
            SUB_SETTLE: begin
                op_a = now_ms;
                op_b = rem;
            end
            default: begin
                op_a = now_ms;
                op_b = step_start;
            end
        endcase
        {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
    end

endmodule

@@ bench/tone_pattern_sequencer_checker.sv @@
`timescale 1ns / 100ps
// checker: predicts tone pattern sequencer results and compares them with the result channel
module tone_pattern_sequencer_checker import tps_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  tps_in_t              s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  tps_out_t             m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   reports_due,
    output int                   report_errors
);

    localparam int SLOT_STEPS = 8;

    localparam int TONE_LEN  [8] = '{3, 1, 3, 5, 3, 2, 4, 3};
    localparam int TONE_REPS [8] = '{0, 0, 1, 0, 0, 0, 0, 0};
    localparam bit TONE_LOOP [8] = '{0, 0, 0, 0, 0, 1, 1, 0};

    localparam int TONE_HZ [64] = '{
        1800, 0, 2400, 0, 0,    0, 0, 0,
        2700, 0, 0,    0, 0,    0, 0, 0,
        2200, 0, 3100, 0, 0,    0, 0, 0,
        2600, 0, 2100, 0, 1600, 0, 0, 0,
        3100, 0, 3100, 0, 0,    0, 0, 0,
        2500, 0, 0,    0, 0,    0, 0, 0,
        3400, 0, 3900, 0, 0,    0, 0, 0,
        1400, 0, 1100, 0, 0,    0, 0, 0
    };

    localparam int TONE_MS [64] = '{
        70,  40,  70,  0,   0,   0, 0, 0,
        250, 0,   0,   0,   0,   0, 0, 0,
        200, 90,  350, 0,   0,   0, 0, 0,
        90,  60,  90,  60,  140, 0, 0, 0,
        120, 70,  120, 0,   0,   0, 0, 0,
        300, 200, 0,   0,   0,   0, 0, 0,
        120, 80,  120, 380, 0,   0, 0, 0,
        200, 120, 300, 0,   0,   0, 0, 0
    };

    logic              mute_on;
    logic [15:0]       prio_map;
    logic              running;
    logic              anchored;
    logic [PAT_W-1:0]  cur_pat;
    logic [POS_W-1:0]  pos;
    logic [7:0]        loops;
    logic [NOW_W-1:0]  t_start;
    logic [PRIO_W-1:0] cur_prio;
    logic [FREQ_W-1:0] prev_tone;

    tps_out_t tone_reports_due [$];

    function automatic logic [FREQ_W-1:0] tone_sounding();
        if (mute_on || !running || pos >= TONE_LEN[cur_pat]) begin
            return '0;
        end
        return FREQ_W'(TONE_HZ[cur_pat * SLOT_STEPS + pos]);
    endfunction

    task automatic halt_playback();
        running = 1'b0;
        pos = '0;
        cur_prio = '0;
        anchored = 1'b0;
    endtask

    task automatic advance_sequencer(input tps_in_t it);
        tps_out_t          r;
        int                len;
        int                guard;
        logic [PRIO_W-1:0] prio;
        logic              ok;
        logic [FREQ_W-1:0] f;
        r = '0;
        case (it.op)
            OP_PLAY: begin
                prio = prio_map[2 * it.pattern_id +: 2];
                ok = TONE_LEN[it.pattern_id] != 0 &&
                     !(running && !it.force_req && prio < cur_prio);
                if (ok) begin
                    cur_pat = it.pattern_id;
                    cur_prio = prio;
                    pos = '0;
                    loops = '0;
                    running = 1'b1;
                    anchored = 1'b0;
                    t_start = it.now_ms;
                end
                r.accepted = ok;
                r.playing = running;
                r.freq_hz = tone_sounding();
                tone_reports_due.push_back(r);
            end
            OP_STOP: begin
                halt_playback();
            end
            OP_STOP_IF: begin
                if (running && cur_pat == it.pattern_id) halt_playback();
            end
            default: begin
                if (running) begin
                    len = TONE_LEN[cur_pat];
                    guard = len * 4 + 4;
                    // catch up through every step that has fully elapsed
                    while (running && anchored && guard > 0 && pos < len &&
                           (it.now_ms - t_start) >=
                           NOW_W'(TONE_MS[cur_pat * SLOT_STEPS + pos])) begin
                        guard--;
                        t_start = t_start + NOW_W'(TONE_MS[cur_pat * SLOT_STEPS + pos]);
                        pos++;
                        if (pos >= len) begin
                            if (TONE_LOOP[cur_pat]) begin
                                pos = '0;
                            end else if (loops < TONE_REPS[cur_pat]) begin
                                loops++;
                                pos = '0;
                            end else begin
                                halt_playback();
                            end
                        end
                    end
                    if (!anchored) begin
                        anchored = 1'b1;
                        t_start = it.now_ms;
                    end
                end
                f = tone_sounding();
                r.playing = running;
                r.freq_hz = f;
                r.changed = f != prev_tone;
                prev_tone = f;
                tone_reports_due.push_back(r);
            end
        endcase
    endtask

    task automatic log_mismatch(input string what, input tps_out_t want, input tps_out_t got);
        report_errors++;
        if (report_errors <= 10) begin
            $display("%t %s: expected acc=%0b play=%0b hz=%0d chg=%0b", $realtime, what,
                     want.accepted, want.playing, want.freq_hz, want.changed);
            $display("%t %s: actual   acc=%0b play=%0b hz=%0d chg=%0b", $realtime, what,
                     got.accepted, got.playing, got.freq_hz, got.changed);
        end
    endtask

    initial begin
        report_errors = 0;
        reports_due = 0;
    end

    always @(posedge aclk) begin
        tps_out_t want;
        if (!aresetn) begin
            mute_on = 1'b0;
            prio_map = PRIO_RESET;
            running = 1'b0;
            anchored = 1'b0;
            cur_pat = '0;
            pos = '0;
            loops = '0;
            t_start = '0;
            cur_prio = '0;
            prev_tone = '0;
            tone_reports_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (tone_reports_due.size() == 0) begin
                    log_mismatch("unexpected result", '0, m_data);
                end else begin
                    want = tone_reports_due.pop_front();
                    if (m_data.accepted !== want.accepted || m_data.playing !== want.playing ||
                        m_data.freq_hz !== want.freq_hz || m_data.changed !== want.changed) begin
                        log_mismatch("result mismatch", want, m_data);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_MUTE) begin
                    mute_on = cfg_data[0];
                end else if (cfg_index == CFG_PRIORITIES) begin
                    prio_map = cfg_data;
                end
            end
            if (s_valid && s_ready) advance_sequencer(s_data);
        end
        reports_due = tone_reports_due.size();
    end

endmodule

@@ bench/tone_pattern_sequencer_tb.sv @@
`timescale 1ns / 100ps
// testbench top: clock, reset, stimulus and verdict for the tone pattern sequencer
module tone_pattern_sequencer_tb;
    import tps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;
    localparam int PHASES           = 8;
    localparam int PHASE_ITEMS      = 165;
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 400;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    tps_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    tps_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   reports_due;
    int                   report_errors;

    logic                 gapless;
    logic                 hold_off_req;
    int                   items_sent;
    logic [NOW_W-1:0]     clock_ms;

    always #1 aclk = ~aclk;

    tone_pattern_sequencer dut (.*);

    tone_pattern_sequencer_checker chk (.*);

    task automatic send_item(input tps_op_t op, input logic [PAT_W-1:0] pid,
                             input logic force_req, input logic [NOW_W-1:0] now_ms);
        tps_in_t it;
        int      gap;
        it.op = op;
        it.pattern_id = pid;
        it.force_req = force_req;
        it.now_ms = now_ms;
        gap = gapless ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic tick_at(input logic [NOW_W-1:0] now_ms);
        send_item(OP_TICK, PAT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), now_ms);
    endtask

    task automatic drain_block();
        s_valid <= 1'b0;
        while (reports_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // play a pattern and follow it with ticks, with the odd preemption or stop mixed in
    task automatic play_song();
        int n;
        clock_ms += $urandom_range(0, 2000);
        send_item(OP_PLAY, PAT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), clock_ms);
        n = $urandom_range(2, 16);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0: send_item(OP_PLAY, PAT_W'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), clock_ms);
                1: send_item(OP_STOP_IF, PAT_W'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), $urandom());
                2: send_item(OP_STOP, PAT_W'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)), $urandom());
                3: begin
                    clock_ms += $urandom();
                    tick_at(clock_ms);
                end
                default: begin
                    clock_ms += $urandom_range(0, 160);
                    tick_at(clock_ms);
                end
            endcase
        end
    endtask

    // result side
    initial begin
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = gapless ? 0 : $urandom_range(0, 19);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = LONG_HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        #1_500_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int   start;
        logic paused;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        gapless = 1'b0;
        hold_off_req = 1'b0;
        items_sent = 0;
        clock_ms = '0;
        paused = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        tick_at(32'd0);
        send_item(OP_PLAY, 3'd0, 1'b0, 32'd1000);
        tick_at(32'd1000);
        tick_at(32'd1069);
        tick_at(32'd1070);
        tick_at(32'd1180);
        send_item(OP_PLAY, 3'd6, 1'b0, 32'd2000);
        tick_at(32'd2000);
        send_item(OP_PLAY, 3'd0, 1'b0, 32'd2010);
        send_item(OP_PLAY, 3'd0, 1'b1, 32'd2010);
        send_item(OP_STOP_IF, 3'd3, 1'b0, 32'd0);
        send_item(OP_STOP_IF, 3'd0, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_STOP, 3'd7, 1'b0, 32'd0);
        send_item(OP_PLAY, 3'd5, 1'b0, 32'hFFFF_FF00);
        tick_at(32'hFFFF_FF00);
        tick_at(32'h0000_0100);
        tick_at(32'h8000_0000);
        send_item(OP_PLAY, 3'd2, 1'b0, 32'd5000);
        tick_at(32'd5000);
        tick_at(32'd5640);
        tick_at(32'd6400);
        send_item(OP_PLAY, 3'd7, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_STOP_IF, 3'd7, 1'b0, 32'd0);
        send_item(OP_PLAY, 3'd4, 1'b0, 32'd0);
        send_item(OP_STOP, 3'd0, 1'b1, 32'hFFFF_FFFF);

        for (int p = 0; p < PHASES; p++) begin
            drain_block();
            case (p)
                0: begin
                    write_reg(CFG_MUTE, 16'd1);
                    write_reg(CFG_PRIORITIES, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_MUTE, 16'd0);
                    write_reg(CFG_PRIORITIES, 16'h0000);
                end
                2: begin
                    write_reg(CFG_MUTE, 16'd0);
                    write_reg(CFG_PRIORITIES, PRIO_RESET);
                end
                default: begin
                    write_reg(CFG_MUTE, CFG_DAT_W'($urandom_range(0, 1)));
                    write_reg(CFG_PRIORITIES, CFG_DAT_W'($urandom()));
                    if (p == 3) write_reg(CFG_UNMAPPED, CFG_DAT_W'($urandom()));
                end
            endcase
            gapless = (p == 5) || ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                // receiver holds off while the sender keeps pushing
                gapless = 1'b1;
                hold_off_req = 1'b1;
            end
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if (p == 4 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_block();
                end
                if ($urandom_range(0, 3) != 0) begin
                    play_song();
                end else begin
                    send_item(tps_op_t'($urandom_range(0, 3)), PAT_W'($urandom_range(0, 7)),
                              1'($urandom_range(0, 1)), $urandom());
                end
            end
            if (p == 2) gapless = 1'b0;
        end

        s_valid <= 1'b0;
        while (reports_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (report_errors == 0 && reports_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
